>>> rtl/core/drive_pair_to_led_color_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the drive pair to LED color block
// Implication checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DRIVE_PAIR_TO_LED_COLOR_TOP_DEFINES_SVH
`define DRIVE_PAIR_TO_LED_COLOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DPLC_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dplc check failed");
`define DPLC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dplc check failed");
`else
`define DPLC_ASSERT_IMPL(lbl, pre, post)
`define DPLC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> rtl/core/dplc_pkg.sv
// ----------------------------------------------------------------------------
// dplc_pkg
// Shared widths, constants and request types of the drive pair color block.
// ----------------------------------------------------------------------------
`default_nettype none

package dplc_pkg;

  localparam int RATIO_FRAC_BITS = 12;

  localparam int DRIVE_W   = 16;
  localparam int SAT_W     = 7;
  localparam int MX_W      = 15;
  localparam int SUM_W     = 16;
  localparam int QUO_W     = RATIO_FRAC_BITS + 2;
  localparam int REM_W     = 15;
  localparam int HUE_MUL_W = 12;
  localparam int NPROD_W   = HUE_MUL_W + QUO_W;
  localparam int D_W       = NPROD_W - RATIO_FRAC_BITS;
  localparam int HUE_W     = 15;
  localparam int W_W       = 12;
  localparam int P_W       = 19;
  localparam int MP_W      = MX_W + P_W;
  localparam int SCL_W     = MP_W + 8;
  localparam int Y_W       = 17;
  localparam int K_W       = 17;
  localparam int QK_W      = Y_W + K_W;
  localparam int BYTE_SHIFT  = 24;
  localparam int RECIP_SHIFT = 25;
  localparam int Q_W       = QK_W - RECIP_SHIFT;
  localparam int NUM_CH    = 3;
  localparam int CH_G      = 0;
  localparam int CH_B      = 1;
  localparam int CH_R      = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = 1;
  localparam int CNT_W      = 2;

  localparam logic [SAT_W-1:0]     SAT_RESET = 7'd100;
  localparam logic [SAT_W-1:0]     SAT_MAX   = 7'd100;
  localparam logic [DRIVE_W:0]     MAG_ONE   = 17'd16384;
  localparam logic [HUE_MUL_W-1:0] HUE_STEP  = 12'd2880;
  localparam logic [HUE_W-1:0]     HUE_LEFT  = 15'd5760;
  localparam logic [HUE_W-1:0]     HUE_RIGHT = 15'd17280;
  localparam logic [HUE_W-1:0]     HUE_S1    = 15'd3840;
  localparam logic [HUE_W-1:0]     HUE_S2    = 15'd7680;
  localparam logic [HUE_W-1:0]     HUE_S3    = 15'd11520;
  localparam logic [HUE_W-1:0]     HUE_S4    = 15'd15360;
  localparam logic [HUE_W-1:0]     HUE_S5    = 15'd19200;
  localparam logic [HUE_W-1:0]     HUE_S6    = 15'd23040;
  localparam logic [W_W-1:0]       W_FULL    = 12'd3840;
  localparam logic [K_W-1:0]       RECIP_K   = 17'd89479;
  localparam logic [QUO_W-1:0]     NMAG_MAX  = {2'b10, {RATIO_FRAC_BITS{1'b0}}};
  localparam logic [7:0]           BYTE_MAX  = 8'hFF;

  localparam logic [2:0] SEXT_R_TO_Y = 3'd0;
  localparam logic [2:0] SEXT_Y_TO_G = 3'd1;
  localparam logic [2:0] SEXT_G_TO_C = 3'd2;
  localparam logic [2:0] SEXT_C_TO_B = 3'd3;
  localparam logic [2:0] SEXT_B_TO_M = 3'd4;
  localparam logic [2:0] SEXT_M_TO_R = 3'd5;

  typedef struct packed {
    logic             oor;
    logic             left_side;
    logic             neg;
    logic [SAT_W-1:0] sat;
    logic [MX_W-1:0]  mx;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [SUM_W-1:0] sum_mag;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

  typedef struct packed {
    logic             valid;
    meta_t            meta;
    logic [QUO_W-1:0] quo;
  } ratio_t;

endpackage

`default_nettype wire

>>> rtl/core/drive_pair_to_led_color_top.sv
// ----------------------------------------------------------------------------
// Path: input queue, divider stages, color stages, then the out_valid register.
// Throughput: one drive pair per cycle unless out_ready stalls the pipeline.
// Reset: synchronous active-low rst_n empties queue and pipeline, saturation 100.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_pair_to_led_color_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dplc_pkg::DRIVE_W-1:0] in_left_drive,
  input  logic signed [dplc_pkg::DRIVE_W-1:0] in_right_drive,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [7:0]                   out_slot0_green,
  output logic        [7:0]                   out_slot1_blue,
  output logic        [7:0]                   out_slot2_red,
  output logic                                out_of_range,
  input  logic                                cfg_we,
  input  logic        [dplc_pkg::SAT_W-1:0]   cfg_wdata
);
  import dplc_pkg::*;

  logic   q_full;
  logic   push;
  req_t   req;
  logic   pop;
  head_t  head;
  ratio_t ratio;
  logic   adv;

  dplc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_drive  (in_left_drive),
    .in_right_drive (in_right_drive),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_full_i       (q_full),
    .push_o         (push),
    .req_o          (req)
  );

  dplc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .req_i  (req),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  dplc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (ratio)
  );

  dplc_color u_color (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_i           (ratio),
    .adv_o           (adv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot0_green (out_slot0_green),
    .out_slot1_blue  (out_slot1_blue),
    .out_slot2_red   (out_slot2_red),
    .out_of_range    (out_of_range)
  );

endmodule

`default_nettype wire

>>> rtl/core/dplc_front.sv
// ----------------------------------------------------------------------------
// dplc_front
// Accept drive pairs, hold saturation, classify range and balance direction.
// ----------------------------------------------------------------------------
`default_nettype none

module dplc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dplc_pkg::DRIVE_W-1:0] in_left_drive,
  input  logic signed [dplc_pkg::DRIVE_W-1:0] in_right_drive,
  input  logic                                cfg_we,
  input  logic        [dplc_pkg::SAT_W-1:0]   cfg_wdata,
  input  logic                                q_full_i,
  output logic                                push_o,
  output dplc_pkg::req_t                      req_o
);
  import dplc_pkg::*;

  logic [SAT_W-1:0]          sat_r;
  logic [SAT_W-1:0]          sat_nxt;
  logic signed [DRIVE_W:0]   l_ext;
  logic signed [DRIVE_W:0]   r_ext;
  logic signed [DRIVE_W:0]   sum;
  logic [DRIVE_W:0]          ml;
  logic [DRIVE_W:0]          mr;
  logic [DRIVE_W:0]          mx;
  logic [DRIVE_W:0]          smag;

  assign l_ext = {in_left_drive[DRIVE_W-1], in_left_drive};
  assign r_ext = {in_right_drive[DRIVE_W-1], in_right_drive};
  assign sum   = l_ext + r_ext;
  assign ml    = l_ext[DRIVE_W] ? (~l_ext + 1'b1) : l_ext;
  assign mr    = r_ext[DRIVE_W] ? (~r_ext + 1'b1) : r_ext;
  assign mx    = (ml > mr) ? ml : mr;
  assign smag  = sum[DRIVE_W] ? (~sum + 1'b1) : sum;

  assign sat_nxt = cfg_we ? cfg_wdata : sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= SAT_RESET;
    end else begin
      sat_r <= sat_nxt;
    end
  end

  always_comb begin
    req_o.meta.oor       = (mx > MAG_ONE) || (sat_r > SAT_MAX);
    req_o.meta.left_side = (in_left_drive <= in_right_drive);
    req_o.meta.neg       = sum[DRIVE_W];
    req_o.meta.sat       = sat_r;
    req_o.meta.mx        = mx[MX_W-1:0];
    req_o.sum_mag        = smag[SUM_W-1:0];
  end

  assign in_ready = !q_full_i;
  assign push_o   = in_valid && !q_full_i;

endmodule

`default_nettype wire

>>> rtl/core/dplc_fifo.sv
// ----------------------------------------------------------------------------
// dplc_fifo
// Two-entry request queue between the front and the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "drive_pair_to_led_color_top_defines.svh"

module dplc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  dplc_pkg::req_t  req_i,
  input  logic            pop_i,
  output logic            full_o,
  output dplc_pkg::head_t head_o
);
  import dplc_pkg::*;

  req_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= req_i;
    end
  end

  assign full_o       = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign head_o.valid = (cnt_r != '0);
  assign head_o.req   = mem_r[rd_ptr_r];

  `DPLC_ASSERT_IMPL(a_no_pop_empty, pop_i, cnt_r != '0)

endmodule

`default_nettype wire

>>> rtl/core/dplc_div.sv
// ----------------------------------------------------------------------------
// dplc_div
// Pipelined restoring divider, one quotient bit per stage, for the ratio.
// ----------------------------------------------------------------------------
`default_nettype none
`include "drive_pair_to_led_color_top_defines.svh"

module dplc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_i,
  input  dplc_pkg::head_t  head_i,
  output logic             pop_o,
  output dplc_pkg::ratio_t res_o
);
  import dplc_pkg::*;

  typedef struct packed {
    meta_t            meta;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] nbits;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    logic [REM_W:0] sh;
    logic [REM_W:0] dv;
    div_stage_t     o;
    o  = s;
    sh = {s.rem, s.nbits[QUO_W-1]};
    dv = {1'b0, s.meta.mx};
    if (sh >= dv) begin
      o.rem = REM_W'(sh - dv);
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = sh[REM_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    o.nbits = {s.nbits[QUO_W-2:0], 1'b0};
    return o;
  endfunction

  div_stage_t   stage_r   [QUO_W+1];
  div_stage_t   stage_nxt [QUO_W+1];
  logic [QUO_W:0] vld_r;
  logic [QUO_W:0] vld_nxt;

  always_comb begin
    stage_nxt[0].meta  = head_i.req.meta;
    stage_nxt[0].rem   = REM_W'(head_i.req.sum_mag[SUM_W-1:2]);
    stage_nxt[0].quo   = '0;
    stage_nxt[0].nbits = {head_i.req.sum_mag[1:0], {RATIO_FRAC_BITS{1'b0}}};
    for (int k = 0; k < QUO_W; k++) begin
      stage_nxt[k+1] = div_step(stage_r[k]);
    end
    vld_nxt = {vld_r[QUO_W-1:0], head_i.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv_i) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int k = 0; k <= QUO_W; k++) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  assign pop_o     = adv_i && head_i.valid;
  assign res_o.valid = vld_r[QUO_W];
  assign res_o.meta  = stage_r[QUO_W].meta;
  assign res_o.quo   = stage_r[QUO_W].quo;

  `DPLC_ASSERT_IMPL(a_ratio_bound, res_o.valid && !res_o.meta.oor && res_o.meta.mx != '0, res_o.quo <= NMAG_MAX)

endmodule

`default_nettype wire

>>> rtl/core/dplc_color.sv
// ----------------------------------------------------------------------------
// dplc_color
// Hue from ratio, sextant weights, scaling to bytes, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "drive_pair_to_led_color_top_defines.svh"

module dplc_color (
  input  logic             clk,
  input  logic             rst_n,
  input  dplc_pkg::ratio_t res_i,
  output logic             adv_o,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_slot0_green,
  output logic [7:0]       out_slot1_blue,
  output logic [7:0]       out_slot2_red,
  output logic             out_of_range
);
  import dplc_pkg::*;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  meta_t                m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;
  logic [NPROD_W-1:0]   nprod1_r;
  logic [NPROD_W-1:0]   nprod1_nxt;
  logic [HUE_W-1:0]     hue2_r;
  logic [HUE_W-1:0]     hue2_nxt;
  logic [2:0]           sext3_r;
  logic [2:0]           sext3_nxt;
  logic [W_W-1:0]       xw3_r;
  logic [W_W-1:0]       xw3_nxt;
  logic [P_W-1:0]       p4_r   [NUM_CH];
  logic [P_W-1:0]       p4_nxt [NUM_CH];
  logic [MP_W-1:0]      mp5_r   [NUM_CH];
  logic [MP_W-1:0]      mp5_nxt [NUM_CH];
  logic [Y_W-1:0]       y6_r   [NUM_CH];
  logic [Y_W-1:0]       y6_nxt [NUM_CH];
  logic [7:0]           byte_r   [NUM_CH];
  logic [7:0]           byte_nxt [NUM_CH];
  logic                 out_valid_r;
  logic                 oor_r;

  logic [QUO_W-1:0]     nmag;
  logic [D_W-1:0]       dval;
  logic [HUE_W-1:0]     hue_base;
  logic [HUE_W-1:0]     fold;
  logic [HUE_W-1:0]     tdist;
  logic [W_W-1:0]       w_ch [NUM_CH];
  logic [SCL_W-1:0]     scl  [NUM_CH];
  logic [QK_W-1:0]      qk   [NUM_CH];
  logic [Q_W-1:0]       qv   [NUM_CH];

  assign adv_o = !out_valid_r || out_ready;

  // ratio to hue
  always_comb begin
    nmag       = (res_i.meta.mx == '0) ? '0 : res_i.quo;
    nprod1_nxt = NPROD_W'(HUE_STEP) * NPROD_W'(nmag);
    dval       = nprod1_r[NPROD_W-1:RATIO_FRAC_BITS];
    hue_base   = m1_r.left_side ? HUE_LEFT : HUE_RIGHT;
    hue2_nxt   = (m1_r.left_side == m1_r.neg) ? hue_base + HUE_W'(dval)
                                              : hue_base - HUE_W'(dval);
  end

  // sextant and falling/rising weight
  always_comb begin
    priority if (hue2_r >= HUE_S5) begin
      sext3_nxt = SEXT_M_TO_R;
    end else if (hue2_r >= HUE_S4) begin
      sext3_nxt = SEXT_B_TO_M;
    end else if (hue2_r >= HUE_S3) begin
      sext3_nxt = SEXT_C_TO_B;
    end else if (hue2_r >= HUE_S2) begin
      sext3_nxt = SEXT_G_TO_C;
    end else if (hue2_r >= HUE_S1) begin
      sext3_nxt = SEXT_Y_TO_G;
    end else begin
      sext3_nxt = SEXT_R_TO_Y;
    end
    priority if (hue2_r >= HUE_S6) begin
      fold = hue2_r - HUE_S6;
    end else if (hue2_r >= HUE_S4) begin
      fold = hue2_r - HUE_S4;
    end else if (hue2_r >= HUE_S2) begin
      fold = hue2_r - HUE_S2;
    end else begin
      fold = hue2_r;
    end
    tdist   = (fold > HUE_S1) ? fold - HUE_S1 : HUE_S1 - fold;
    xw3_nxt = W_FULL - tdist[W_W-1:0];
  end

  // channel weights
  always_comb begin
    unique case (sext3_r)
      SEXT_R_TO_Y: begin
        w_ch[CH_R] = W_FULL; w_ch[CH_G] = xw3_r;  w_ch[CH_B] = '0;
      end
      SEXT_Y_TO_G: begin
        w_ch[CH_R] = xw3_r;  w_ch[CH_G] = W_FULL; w_ch[CH_B] = '0;
      end
      SEXT_G_TO_C: begin
        w_ch[CH_R] = '0;     w_ch[CH_G] = W_FULL; w_ch[CH_B] = xw3_r;
      end
      SEXT_C_TO_B: begin
        w_ch[CH_R] = '0;     w_ch[CH_G] = xw3_r;  w_ch[CH_B] = W_FULL;
      end
      SEXT_B_TO_M: begin
        w_ch[CH_R] = xw3_r;  w_ch[CH_G] = '0;     w_ch[CH_B] = W_FULL;
      end
      default: begin
        w_ch[CH_R] = W_FULL; w_ch[CH_G] = '0;     w_ch[CH_B] = xw3_r;
      end
    endcase
    for (int c = 0; c < NUM_CH; c++) begin
      p4_nxt[c] = P_W'(m3_r.sat) * P_W'(w_ch[c])
                + P_W'(SAT_MAX - m3_r.sat) * P_W'(W_FULL);
    end
  end

  // scale by magnitude, then by 255 over the full-scale product
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      mp5_nxt[c]  = MP_W'(m4_r.mx) * MP_W'(p4_r[c]);
      scl[c]      = (SCL_W'(mp5_r[c]) << 8) - SCL_W'(mp5_r[c]);
      y6_nxt[c]   = scl[c][BYTE_SHIFT +: Y_W];
      qk[c]       = QK_W'(y6_r[c]) * QK_W'(RECIP_K);
      qv[c]       = qk[c][QK_W-1:RECIP_SHIFT];
      if (m6_r.oor) begin
        byte_nxt[c] = '0;
      end else if (qv[c] > Q_W'(BYTE_MAX)) begin
        byte_nxt[c] = BYTE_MAX;
      end else begin
        byte_nxt[c] = qv[c][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv_o) begin
      v1_r        <= res_i.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      m1_r     <= res_i.meta;
      m2_r     <= m1_r;
      m3_r     <= m2_r;
      m4_r     <= m3_r;
      m5_r     <= m4_r;
      m6_r     <= m5_r;
      nprod1_r <= nprod1_nxt;
      hue2_r   <= hue2_nxt;
      sext3_r  <= sext3_nxt;
      xw3_r    <= xw3_nxt;
      oor_r    <= m6_r.oor;
      for (int c = 0; c < NUM_CH; c++) begin
        p4_r[c]   <= p4_nxt[c];
        mp5_r[c]  <= mp5_nxt[c];
        y6_r[c]   <= y6_nxt[c];
        byte_r[c] <= byte_nxt[c];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot0_green = byte_r[CH_G];
  assign out_slot1_blue  = byte_r[CH_B];
  assign out_slot2_red   = byte_r[CH_R];
  assign out_of_range    = oor_r;

  `DPLC_ASSERT_IMPL(a_oor_black, out_valid_r && oor_r, byte_r[CH_G] == '0 && byte_r[CH_B] == '0 && byte_r[CH_R] == '0)
  `DPLC_ASSERT_IMPL(a_out_from_pipe, $rose(out_valid_r), $past(v6_r))
  `DPLC_ASSERT_NEXT(a_stall_holds_pipe, !adv_o, $stable(v6_r) && $stable(v1_r))

endmodule

`default_nettype wire
